// ===== rtl/core/csvt_pkg.sv =====
// csvt_pkg: shared types and character codes for the CSV field tokenizer.
// No dependencies; every csvt module refers to it by scoped names.
`default_nettype none

package csvt_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KindW = 2;

    localparam logic [ByteW-1:0] ChQuote = 8'h22;
    localparam logic [ByteW-1:0] ChComma = 8'h2C;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;

    typedef enum logic [KindW-1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } t_kind;

    // Parser flags carried from byte to byte
    typedef struct packed {
        logic in_quoted_field;
        logic quote_pending;
        logic skip_line_feed;
        logic field_nonempty;
        logic row_nonempty;
    } t_flags;

    // One token leaving the parser core
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] char_val;
        t_kind            kind;
    } t_token;

endpackage

`default_nettype wire

// ===== rtl/core/csv_field_tokenizer.sv =====
// csv_field_tokenizer: top level of the streaming CSV tokenizer.
// Depends on csvt_pkg, csvt_in_stage, csvt_core and csvt_out_reg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one text byte, or an
//   end-of-data mark in i_end_of_data, per transfer. Output channel
//   (o_out_valid / i_out_stall) carries tokens: o_out_kind 0 is a field data
//   byte in o_out_char, 1 ends a field, 2 ends the field and the row
//   (o_out_char is 0 for kinds 1 and 2). A byte yields zero or one token.
//   A transferred byte is held in the input register, decoded from it, and
//   its token is loaded into the output register, from which it can then
//   transfer out. Throughput: one byte per cycle while the output is not
//   stalled; the parser flags are updated by one level of decode logic
//   between the input and the output register.
//   Stall: when the output register holds an untaken token and i_out_stall is
//   high, the byte in the input register holds and o_in_stall rises; bytes
//   that give no token still wait for that slot, so order is kept.
//   Reset (i_rst_n low, synchronous): both registers empty and all parser
//   flags cleared; an end-of-data item clears the flags the same way.
`default_nettype none

module csv_field_tokenizer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [csvt_pkg::ByteW-1:0] i_in_byte,
    input  wire logic                       i_end_of_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [csvt_pkg::ByteW-1:0]      o_out_char,
    output logic [csvt_pkg::KindW-1:0]      o_out_kind
);

    logic                       out_free;
    logic                       s1_valid;
    logic [csvt_pkg::ByteW-1:0] s1_byte;
    logic                       s1_eod;
    logic                       step;
    csvt_pkg::t_token           token;

    // Advance the held byte whenever the result slot can take its token
    assign step = s1_valid && out_free;

    csvt_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_end_of_data (i_end_of_data),
        .o_in_stall    (o_in_stall),
        .i_out_free    (out_free),
        .o_valid       (s1_valid),
        .o_byte        (s1_byte),
        .o_eod         (s1_eod)
    );

    csvt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (s1_byte),
        .i_eod   (s1_eod),
        .o_token (token)
    );

    csvt_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_token     (token),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_out_kind  (o_out_kind)
    );

endmodule

`default_nettype wire

// ===== rtl/core/csvt_in_stage.sv =====
// csvt_in_stage: input register of the tokenizer with its stall generation.
// Depends on csvt_pkg for the byte width.
`default_nettype none

module csvt_in_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [csvt_pkg::ByteW-1:0] i_in_byte,
    input  wire logic                      i_end_of_data,
    output logic                           o_in_stall,
    input  wire logic                      i_out_free,
    output logic                           o_valid,
    output logic [csvt_pkg::ByteW-1:0]     o_byte,
    output logic                           o_eod
);

    logic                       r_valid;
    logic [csvt_pkg::ByteW-1:0] r_byte;
    logic                       r_eod;
    logic                       load;

    // Hold the item while the result side cannot take its token
    assign o_in_stall = r_valid && !i_out_free;
    assign load       = !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_byte <= i_in_byte;
            r_eod  <= i_end_of_data;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eod   = r_eod;

endmodule

`default_nettype wire

// ===== rtl/core/csvt_core.sv =====
// csvt_core: parser flags and the per-byte decode into one optional token.
// Depends on csvt_pkg for flag and token types and the character codes.
`default_nettype none

module csvt_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [csvt_pkg::ByteW-1:0] i_byte,
    input  wire logic                       i_eod,
    output csvt_pkg::t_token                o_token
);

    csvt_pkg::t_flags r_flags;
    csvt_pkg::t_flags n_flags;

    always_comb begin
        logic plain;
        plain           = 1'b0;
        n_flags         = r_flags;
        o_token.valid    = 1'b0;
        o_token.char_val = '0;
        o_token.kind     = csvt_pkg::KIND_DATA;

        if (i_eod) begin
            // Flush a non-empty last row, then drop all state
            o_token.valid = r_flags.field_nonempty || r_flags.row_nonempty;
            o_token.kind  = csvt_pkg::KIND_ROW;
            n_flags       = '0;
        end else begin
            n_flags.skip_line_feed = 1'b0;
            if (r_flags.skip_line_feed && i_byte == csvt_pkg::ChLf) begin
                // swallow LF of CRLF
            end else if (r_flags.quote_pending) begin
                n_flags.quote_pending = 1'b0;
                if (i_byte == csvt_pkg::ChQuote) begin
                    n_flags.field_nonempty = 1'b1;
                    o_token.valid          = 1'b1;
                    o_token.char_val       = csvt_pkg::ChQuote;
                end else begin
                    // section closes; byte falls through as unquoted text
                    n_flags.in_quoted_field = 1'b0;
                    plain                   = 1'b1;
                end
            end else if (r_flags.in_quoted_field) begin
                if (i_byte == csvt_pkg::ChQuote) begin
                    n_flags.quote_pending = 1'b1;
                end else begin
                    n_flags.field_nonempty = 1'b1;
                    o_token.valid          = 1'b1;
                    o_token.char_val       = i_byte;
                end
            end else begin
                plain = 1'b1;
            end

            if (plain) begin
                if (i_byte == csvt_pkg::ChQuote) begin
                    n_flags.in_quoted_field = 1'b1;
                end else if (i_byte == csvt_pkg::ChComma) begin
                    n_flags.field_nonempty = 1'b0;
                    n_flags.row_nonempty   = 1'b1;
                    o_token.valid          = 1'b1;
                    o_token.kind           = csvt_pkg::KIND_FIELD;
                end else if (i_byte == csvt_pkg::ChLf || i_byte == csvt_pkg::ChCr) begin
                    n_flags.skip_line_feed = (i_byte == csvt_pkg::ChCr);
                    n_flags.field_nonempty = 1'b0;
                    n_flags.row_nonempty   = 1'b0;
                    o_token.valid          = 1'b1;
                    o_token.kind           = csvt_pkg::KIND_ROW;
                end else begin
                    n_flags.field_nonempty = 1'b1;
                    o_token.valid          = 1'b1;
                    o_token.char_val       = i_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_step) begin
            r_flags <= n_flags;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/csvt_out_reg.sv =====
// csvt_out_reg: result register holding one token until the receiver takes it.
// Depends on csvt_pkg for the token type.
`default_nettype none

module csvt_out_reg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  csvt_pkg::t_token           i_token,
    input  wire logic                  i_out_stall,
    output logic                       o_free,
    output logic                       o_out_valid,
    output logic [csvt_pkg::ByteW-1:0] o_out_char,
    output logic [csvt_pkg::KindW-1:0] o_out_kind
);

    logic                       r_valid;
    logic [csvt_pkg::ByteW-1:0] r_char;
    csvt_pkg::t_kind            r_kind;

    // Free when empty or when the held token transfers this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_step && i_token.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_step && i_token.valid) begin
            r_char <= i_token.char_val;
            r_kind <= i_token.kind;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_char  = r_char;
    assign o_out_kind  = r_kind;

endmodule

`default_nettype wire
